>>> sv/atap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the aligned transfer address planner.
// No dependencies; imported by aligned_transfer_address_planner_core.

package atap_pkg;

    localparam int ID_COUNT_DEF = 1024;

    localparam int ID_W   = 10;
    localparam int SIZE_W = 32;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 11;
    localparam int ALW_W  = 4;
    localparam int MASK_W = 12;

    localparam logic [ALW_W-1:0] ALIGN_LOG2_RESET = 4'd6;
    localparam logic [ALW_W-1:0] ALIGN_LOG2_MAX   = 4'd12;

    localparam logic REG_ALIGN_LOG2 = 1'b0;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_ALLOC   = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_COLLECT,
        ST_QUERY,
        ST_ALLOC,
        ST_DRAIN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

>>> sv/aligned_transfer_address_planner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Aligned transfer address planner: size table, base table, allocate walk.
// Depends on atap_pkg.
//
//  port group   direction  handshake          payload
//  s_*          in         s_valid / s_ready  s_mode, s_transfer_id, s_size_bytes
//  m_*          out        m_valid / m_ready  m_address, m_found, m_block_count
//  APB          in/out     psel, penable      paddr, pwdata, prdata (alignment_log2)
//
//  Collect and query: table read, modify/write, result.
//  Clear and allocate step through the tables one table entry per cycle.
//  After reset the tables are swept with s_ready low.
//  One item at a time; a new item is taken while the last result waits on m_ready.

module aligned_transfer_address_planner_core
    import atap_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_mode,
    input  wire logic [ID_W-1:0]   s_transfer_id,
    input  wire logic [SIZE_W-1:0] s_size_bytes,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_address,
    output logic                   m_found,
    output logic [CNT_W-1:0]       m_block_count,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int IDX_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ID_COUNT - 1);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic [ALW_W-1:0] align_reg;
    logic [ALW_W-1:0] eff_log2;
    logic [MASK_W:0]  align_one;
    logic [MASK_W-1:0] align_mask;

    logic [ID_W-1:0]   id_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              in_range_reg;

    logic [ADDR_W-1:0] fp_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [SIZE_W:0]   mem_a [ID_COUNT];
    logic [ADDR_W:0]   mem_b [ID_COUNT];
    logic [SIZE_W:0]   a_rdata_reg;
    logic [ADDR_W:0]   b_rdata_reg;

    logic              a_we, b_we;
    logic [IDX_W-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
    logic [SIZE_W:0]   a_wdata;
    logic [ADDR_W:0]   b_wdata;

    logic              p1_vld_reg, p2_vld_reg, p2_seen_reg;
    logic [IDX_W-1:0]  p1_idx_reg, p2_idx_reg;
    logic [SIZE_W:0]   p2_rsize_reg;

    logic [ADDR_W-1:0] res_addr_reg;
    logic              res_found_reg;

    logic              m_valid_reg, m_found_reg;
    logic [ADDR_W-1:0] m_address_reg;
    logic [CNT_W-1:0]  m_block_count_reg;

    logic              s_fire, out_free, cnt_last, in_range_in, cfg_wr;
    logic [IDX_W-1:0]  in_idx, id_idx;
    logic [SIZE_W-1:0] size_max;

    assign eff_log2   = (align_reg > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : align_reg;
    assign align_one  = (MASK_W + 1)'(1) << eff_log2;
    assign align_mask = MASK_W'(align_one - (MASK_W + 1)'(1));

    assign s_fire      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign cnt_last    = (cnt_reg == IDX_LAST);
    assign in_idx      = IDX_W'(s_transfer_id);
    assign id_idx      = IDX_W'(id_reg);
    assign in_range_in = (32'(s_transfer_id) < 32'(ID_COUNT));
    assign size_max    = (!a_rdata_reg[SIZE_W] || (a_rdata_reg[SIZE_W-1:0] < size_reg))
                         ? size_reg : a_rdata_reg[SIZE_W-1:0];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ALIGN_LOG2);
    assign prdata = (paddr[2] == REG_ALIGN_LOG2) ? {28'd0, align_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg <= ALIGN_LOG2_RESET;
        end else if (cfg_wr) begin
            align_reg <= pwdata[ALW_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            ST_INIT: begin
                cnt_next = cnt_last ? '0 : cnt_reg + IDX_W'(1);
                if (cnt_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (mode_t'(s_mode))
                        MODE_CLEAR:   state_next = ST_CLEAR;
                        MODE_COLLECT: state_next = ST_COLLECT;
                        MODE_ALLOC:   state_next = ST_ALLOC;
                        MODE_QUERY:   state_next = ST_QUERY;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                cnt_next = cnt_last ? '0 : cnt_reg + IDX_W'(1);
                if (cnt_last) state_next = ST_RESP;
            end
            ST_COLLECT: state_next = ST_RESP;
            ST_QUERY:   state_next = ST_RESP;
            ST_ALLOC: begin
                cnt_next = cnt_last ? '0 : cnt_reg + IDX_W'(1);
                if (cnt_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!p1_vld_reg && !p2_vld_reg) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // table access control
    always_comb begin
        s_ready = 1'b0;
        a_we    = 1'b0;
        a_waddr = cnt_reg;
        a_wdata = '0;
        b_we    = 1'b0;
        b_waddr = cnt_reg;
        b_wdata = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                a_we = 1'b1;
                b_we = 1'b1;
            end
            ST_IDLE: s_ready = 1'b1;
            ST_COLLECT: begin
                a_we    = in_range_reg && (size_reg != '0);
                a_waddr = id_idx;
                a_wdata = {1'b1, size_max};
            end
            ST_ALLOC, ST_DRAIN: begin
                b_we    = p2_vld_reg;
                b_waddr = p2_idx_reg;
                b_wdata = {p2_seen_reg, fp_reg};
            end
            default: begin
            end
        endcase
    end

    assign a_raddr = (state_reg == ST_ALLOC) ? cnt_reg : in_idx;
    assign b_raddr = in_idx;

    always_ff @(posedge aclk) begin
        if (a_we) begin
            mem_a[a_waddr] <= a_wdata;
        end
        a_rdata_reg <= mem_a[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            mem_b[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= mem_b[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            id_reg       <= s_transfer_id;
            size_reg     <= s_size_bytes;
            in_range_reg <= in_range_in;
        end
    end

    // allocate walk: read, round size, commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= (state_reg == ST_ALLOC);
            p2_vld_reg <= p1_vld_reg;
        end
        p1_idx_reg   <= cnt_reg;
        p2_idx_reg   <= p1_idx_reg;
        p2_seen_reg  <= a_rdata_reg[SIZE_W];
        p2_rsize_reg <= ({1'b0, a_rdata_reg[SIZE_W-1:0]} + (SIZE_W + 1)'(align_mask))
                        & ~(SIZE_W + 1)'(align_mask);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg    <= '0;
            count_reg <= '0;
        end else if (s_fire && ((mode_t'(s_mode) == MODE_CLEAR)
                                || (mode_t'(s_mode) == MODE_ALLOC))) begin
            fp_reg    <= '0;
            count_reg <= '0;
        end else if (p2_vld_reg && p2_seen_reg) begin
            fp_reg    <= fp_reg + ADDR_W'(p2_rsize_reg);
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_CLEAR, ST_COLLECT: begin
                res_addr_reg  <= '0;
                res_found_reg <= 1'b0;
            end
            ST_QUERY: begin
                if (in_range_reg && b_rdata_reg[ADDR_W]) begin
                    res_addr_reg  <= b_rdata_reg[ADDR_W-1:0];
                    res_found_reg <= 1'b1;
                end else begin
                    res_addr_reg  <= ADDR_W'(id_reg) << eff_log2;
                    res_found_reg <= 1'b0;
                end
            end
            ST_DRAIN: begin
                res_addr_reg  <= fp_reg;
                res_found_reg <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_RESP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if ((state_reg == ST_RESP) && out_free) begin
            m_address_reg     <= res_addr_reg;
            m_found_reg       <= res_found_reg;
            m_block_count_reg <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_address     = m_address_reg;
    assign m_found       = m_found_reg;
    assign m_block_count = m_block_count_reg;

    a_fp_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ALLOC) || (state_reg == ST_DRAIN))
        |-> ((fp_reg & ADDR_W'(align_mask)) == '0))
        else $error("fill pointer lost alignment during allocate");

    a_alloc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (mode_t'(s_mode) == MODE_ALLOC)) |=> ((fp_reg == '0) && (count_reg == '0)))
        else $error("allocate did not restart fill pointer");

    a_size_write_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        a_we |-> ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)
                  || (state_reg == ST_COLLECT)))
        else $error("size table written outside sweep or collect");

    a_pipe_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_vld_reg |-> ((state_reg == ST_ALLOC) || (state_reg == ST_DRAIN)))
        else $error("allocate pipeline active outside walk");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RESP) && out_free) |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not presented");

endmodule

`default_nettype wire

>>> sim/tb_aligned_transfer_address_planner_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for aligned_transfer_address_planner_core: random
// clear/collect/allocate/query traffic checked against an in-bench address plan.
// Depends on atap_pkg and the core; no other files.

module tb_aligned_transfer_address_planner_core;
    import atap_pkg::*;

    localparam int TB_IDS      = ID_COUNT_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASE_ITEMS = 100;
    localparam logic [2:0] ALIGN_REG_ADDR = {REG_ALIGN_LOG2, 2'b00};

    typedef struct packed {
        mode_t             mode;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } plan_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              found;
        logic [CNT_W-1:0]  block_count;
    } plan_reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_mode = 2'd0;
    logic [ID_W-1:0]   s_transfer_id = '0;
    logic [SIZE_W-1:0] s_size_bytes = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ADDR_W-1:0] m_address;
    logic              m_found;
    logic [CNT_W-1:0]  m_block_count;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    aligned_transfer_address_planner_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_transfer_id (s_transfer_id),
        .s_size_bytes  (s_size_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_address     (m_address),
        .m_found       (m_found),
        .m_block_count (m_block_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // plan state
    logic [SIZE_W-1:0] size_table [TB_IDS];
    logic              seen_flag [TB_IDS];
    logic [ADDR_W-1:0] base_table [TB_IDS];
    logic              placed_flag [TB_IDS];
    logic [ADDR_W-1:0] fill_ptr = '0;
    logic [CNT_W-1:0]  placed_count = '0;
    logic [ALW_W-1:0]  align_log2 = ALIGN_LOG2_RESET;

    plan_item_t  item_backlog[$];
    plan_reply_t awaited_replies[$];
    plan_item_t  on_wire;
    int          send_wait = 0;
    int          recv_wait = 0;
    logic        send_idle = 1'b0;
    logic        recv_idle = 1'b0;
    int          fault_count = 0;
    int          cycle_count = 0;

    function automatic logic [ADDR_W-1:0] round_to_align(input logic [63:0] v,
                                                         input int unsigned sh);
        logic [63:0] mask;
        mask = (64'd1 << sh) - 64'd1;
        return ADDR_W'((v + mask) & ~mask);
    endfunction

    function automatic plan_reply_t predict_plan(input plan_item_t it);
        plan_reply_t       r;
        logic [ADDR_W-1:0] base;
        int unsigned       shift;
        r.address = '0;
        r.found   = 1'b0;
        shift = 32'((align_log2 > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : align_log2);
        case (it.mode)
            MODE_CLEAR: begin
                for (int k = 0; k < TB_IDS; k++) begin
                    seen_flag[k]   = 1'b0;
                    placed_flag[k] = 1'b0;
                end
                fill_ptr     = '0;
                placed_count = '0;
            end
            MODE_COLLECT: begin
                if (it.size != '0 && it.id < TB_IDS) begin
                    if (!seen_flag[it.id] || size_table[it.id] < it.size)
                        size_table[it.id] = it.size;
                    seen_flag[it.id] = 1'b1;
                end
            end
            MODE_ALLOC: begin
                fill_ptr     = '0;
                placed_count = '0;
                for (int k = 0; k < TB_IDS; k++) begin
                    placed_flag[k] = 1'b0;
                    if (seen_flag[k]) begin
                        base           = round_to_align({16'b0, fill_ptr}, shift);
                        base_table[k]  = base;
                        placed_flag[k] = 1'b1;
                        fill_ptr       = base + round_to_align({32'b0, size_table[k]}, shift);
                        placed_count   = placed_count + CNT_W'(1);
                    end
                end
                r.address = fill_ptr;
            end
            default: begin
                if (it.id < TB_IDS && placed_flag[it.id]) begin
                    r.address = base_table[it.id];
                    r.found   = 1'b1;
                end else begin
                    r.address = ADDR_W'(it.id) << shift;
                end
            end
        endcase
        r.block_count = placed_count;
        return r;
    endfunction

    task automatic push_item(input mode_t mode, input int unsigned id,
                             input logic [SIZE_W-1:0] size);
        plan_item_t it;
        it.mode = mode;
        it.id   = ID_W'(id);
        it.size = size;
        item_backlog = {item_backlog, it};
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (item_backlog.size() != 0 || s_valid || awaited_replies.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_alignment(input logic [ALW_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ALIGN_REG_ADDR;
        pwdata  <= {28'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        align_log2 = value;
    endtask

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        for (int k = 0; k < TB_IDS; k++) begin
            size_table[k]  = '0;
            seen_flag[k]   = 1'b0;
            base_table[k]  = '0;
            placed_flag[k] = 1'b0;
        end
    end

    // drive items from the backlog
    always @(posedge aclk) begin : drive_items
        logic        v_next;
        plan_reply_t reply;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            v_next = s_valid;
            if (s_valid && s_ready) begin
                reply = predict_plan(on_wire);
                awaited_replies = {awaited_replies, reply};
                v_next    = 1'b0;
                send_wait = send_idle ? $urandom_range(0, 8) : 0;
            end
            if (!v_next) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (item_backlog.size() != 0) begin
                    on_wire = item_backlog.pop_front();
                    v_next  = 1'b1;
                end
            end
            s_valid <= v_next;
            if (v_next) begin
                s_mode        <= on_wire.mode;
                s_transfer_id <= on_wire.id;
                s_size_bytes  <= on_wire.size;
            end
        end
    end

    // check results and stall the result side
    always @(posedge aclk) begin : watch_replies
        logic        r_next;
        plan_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            r_next = m_ready;
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected item address %h found %b count %0d",
                             $time, m_address, m_found, m_block_count);
                    fault_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_address !== want.address) begin
                        $display("%0t: address expected %h got %h",
                                 $time, want.address, m_address);
                        fault_count++;
                    end
                    if (m_found !== want.found) begin
                        $display("%0t: found expected %b got %b",
                                 $time, want.found, m_found);
                        fault_count++;
                    end
                    if (m_block_count !== want.block_count) begin
                        $display("%0t: block_count expected %0d got %0d",
                                 $time, want.block_count, m_block_count);
                        fault_count++;
                    end
                end
                r_next    = 1'b0;
                recv_wait = recv_idle ? $urandom_range(0, 8) : 0;
            end
            if (!r_next) begin
                if (recv_wait > 0)
                    recv_wait--;
                else
                    r_next = 1'b1;
            end
            m_ready <= r_next;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("aligned_transfer_address_planner_core test failed");
        $finish;
    end

    initial begin
        int unsigned       pool [8];
        int unsigned       n_collect;
        int unsigned       n_query;
        int unsigned       id;
        logic [SIZE_W-1:0] size;
        logic [ALW_W-1:0]  align_pick;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items at the reset alignment
        @(negedge aclk);
        push_item(MODE_QUERY, 0, '0);
        push_item(MODE_QUERY, TB_IDS - 1, 32'hFFFF_FFFF);
        push_item(MODE_COLLECT, 0, 32'd0);
        push_item(MODE_COLLECT, 5, 32'd100);
        push_item(MODE_COLLECT, 5, 32'd50);
        push_item(MODE_COLLECT, 5, 32'd200);
        push_item(MODE_COLLECT, TB_IDS - 1, 32'hFFFF_FFFF);
        push_item(MODE_COLLECT, 0, 32'd1);
        push_item(MODE_COLLECT, 512, 32'd64);
        push_item(MODE_ALLOC, 0, '0);
        push_item(MODE_QUERY, 5, '0);
        push_item(MODE_QUERY, TB_IDS - 1, '0);
        push_item(MODE_QUERY, 0, '0);
        push_item(MODE_QUERY, 512, '0);
        push_item(MODE_QUERY, 7, '0);
        push_item(MODE_ALLOC, 1023, 32'hFFFF_FFFF);
        push_item(MODE_QUERY, 5, '0);
        push_item(MODE_CLEAR, 0, '0);
        push_item(MODE_QUERY, 5, '0);
        push_item(MODE_ALLOC, 0, '0);
        push_item(MODE_COLLECT, 3, 32'h8000_0000);
        push_item(MODE_COLLECT, 682, 32'h5555_5555);
        push_item(MODE_ALLOC, 0, '0);
        push_item(MODE_QUERY, 682, '0);

        for (int phase = 0; phase < 8; phase++) begin
            wait_quiet();
            case (phase)
                0:       align_pick = 4'd0;
                1:       align_pick = ALIGN_LOG2_MAX;
                2:       align_pick = 4'd15;
                3:       align_pick = 4'd13;
                default: align_pick = ALW_W'($urandom_range(0, 15));
            endcase
            write_alignment(align_pick);
            @(negedge aclk);
            send_idle = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
            recv_idle = (phase <= 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

            while (item_backlog.size() < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    for (int k = 0; k < 8; k++)
                        pool[k] = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, TB_IDS - 1);
                    if ($urandom_range(0, 9) < 3)
                        push_item(MODE_CLEAR, $urandom_range(0, TB_IDS - 1), $urandom);
                    n_collect = $urandom_range(1, 10);
                    for (int k = 0; k < n_collect; k++) begin
                        case ($urandom_range(0, 5))
                            0:       size = '0;
                            1:       size = $urandom_range(1, 4096);
                            2:       size = $urandom;
                            3:       size = 32'hFFFF_FFFF;
                            4:       size = $urandom_range(1, 64) << 6;
                            default: size = $urandom_range(1, 300);
                        endcase
                        push_item(MODE_COLLECT, pool[$urandom_range(0, 7)], size);
                    end
                    push_item(MODE_ALLOC, $urandom_range(0, TB_IDS - 1), $urandom);
                    n_query = $urandom_range(1, 8);
                    for (int k = 0; k < n_query; k++) begin
                        id = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)]
                                                         : $urandom_range(0, TB_IDS - 1);
                        push_item(MODE_QUERY, id, $urandom);
                    end
                end else begin
                    case ($urandom_range(0, 9))
                        0:       push_item(MODE_CLEAR, $urandom_range(0, TB_IDS - 1), $urandom);
                        1:       push_item(MODE_ALLOC, $urandom_range(0, TB_IDS - 1), $urandom);
                        2, 3, 4: push_item(MODE_QUERY, $urandom_range(0, TB_IDS - 1), $urandom);
                        default: push_item(MODE_COLLECT, $urandom_range(0, TB_IDS - 1), $urandom);
                    endcase
                end
            end
        end

        wait_quiet();
        repeat (TB_IDS + 16) @(posedge aclk);
        if (fault_count == 0 && awaited_replies.size() == 0) begin
            $display("aligned_transfer_address_planner_core test passed");
        end else begin
            $display("aligned_transfer_address_planner_core test failed");
        end
        $finish;
    end

endmodule
